// File: rtl/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types, byte codes and the ASCII hex nibble helper for the ignition
// packet decoder.
// ----------------------------------------------------------------------------
package ipd_pkg;

	localparam int unsigned WIN_DEPTH = 4;
	localparam int unsigned CNT_W     = 3;

	localparam logic [7:0] PAD_BYTE = 8'h24;
	localparam logic [7:0] TERM_SP  = 8'h20;
	localparam logic [7:0] TERM_CR  = 8'h0D;
	localparam logic [7:0] TUNE_ON  = 8'h31;

	localparam logic [7:0] CMD_RPM  = 8'h30;
	localparam logic [7:0] CMD_ADV  = 8'h31;
	localparam logic [7:0] CMD_PRES = 8'h32;
	localparam logic [7:0] CMD_TEMP = 8'h33;
	localparam logic [7:0] CMD_TUNE = 8'h34;
	localparam logic [7:0] CMD_CUR  = 8'h35;
	localparam logic [7:0] CMD_VOLT = 8'h41;

	typedef enum logic [2:0] {
		QTY_RPM  = 3'd0,
		QTY_ADV  = 3'd1,
		QTY_PRES = 3'd2,
		QTY_TEMP = 3'd3,
		QTY_TUNE = 3'd4,
		QTY_CUR  = 3'd5,
		QTY_VOLT = 3'd6
	} qty_t;

	// per-cell load controls
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	// decoded packet
	typedef struct packed {
		logic               hit;
		qty_t               qty;
		logic signed [14:0] value;
		logic [7:0]         code;
	} dec_res_t;

	// non-hex characters count as zero
	function automatic logic [3:0] nib_of(input logic [7:0] c);
		logic [3:0] n;
		n = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			n = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			n = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			n = 4'(c - 8'h57);
		end
		return n;
	endfunction

endpackage

// File: rtl/ipd_cell.sv
// ----------------------------------------------------------------------------
// ipd_cell
// One byte slot of the receive window. Takes the new byte when it is the
// next free slot, or its right neighbor's byte when the window slides.
// ----------------------------------------------------------------------------
module ipd_cell
	import ipd_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic [7:0] new_byte,
	input  logic [7:0] next_byte,
	output logic [7:0] byte_q
);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= new_byte;
		end else if (ctrl.shift) begin
			byte_q <= next_byte;
		end
	end

endmodule

// File: rtl/ipd_decode.sv
// ----------------------------------------------------------------------------
// ipd_decode
// Turns the command, msb and lsb characters of a packet into a quantity
// code, a scaled value and the raw byte.
// ----------------------------------------------------------------------------
module ipd_decode
	import ipd_pkg::*;
(
	input  logic [7:0] cmd,
	input  logic [7:0] msb,
	input  logic [7:0] lsb,
	input  logic       sim_active,
	output dec_res_t   res
);

	logic [3:0]  hi;
	logic [3:0]  lo;
	logic [7:0]  code;
	logic [13:0] rpm_v;
	logic [15:0] cur_p;
	logic [18:0] vol_p;

	assign hi    = nib_of(msb);
	assign lo    = nib_of(lsb);
	assign code  = {hi, lo};
	assign rpm_v = {10'd0, hi} * 14'd800 + {10'd0, lo} * 14'd50;
	// scale by 185/16 and 1410/64, truncate
	assign cur_p = {8'd0, code} * 16'd185;
	assign vol_p = {11'd0, code} * 19'd1410;

	always_comb begin
		res.hit   = 1'b1;
		res.qty   = QTY_RPM;
		res.value = '0;
		res.code  = code;
		unique case (cmd)
			CMD_RPM: begin
				res.hit   = ~sim_active;
				res.value = $signed({1'b0, rpm_v});
			end
			CMD_ADV: begin
				res.qty   = QTY_ADV;
				res.value = $signed({6'd0, code, 1'b0});
			end
			CMD_PRES: begin
				res.qty   = QTY_PRES;
				res.value = $signed({7'd0, code});
			end
			CMD_TEMP: begin
				res.qty   = QTY_TEMP;
				res.value = $signed({7'd0, code}) - 15'sd30;
			end
			CMD_TUNE: begin
				res.qty   = QTY_TUNE;
				res.value = $signed({14'd0, lsb == TUNE_ON});
			end
			CMD_CUR: begin
				res.qty   = QTY_CUR;
				res.value = $signed({3'd0, cur_p[15:4]});
			end
			CMD_VOLT: begin
				res.qty   = QTY_VOLT;
				res.value = $signed({2'd0, vol_p[18:6]});
			end
			default: begin
				res.hit = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/ignition_packet_decoder_core.sv
// ----------------------------------------------------------------------------
// ignition_packet_decoder_core
// Takes one received link byte per cycle and decodes five-byte ASCII packets
// (command, msb, lsb, check, terminator). Padding 0x24 is dropped; a clear
// beat empties the window. The window is a row of four byte cells; a fifth
// byte that is not a terminator slides the row by one to resync. On a good
// terminator the packet is decoded in the same cycle and the result appears
// on the result port in the next cycle, held in a single output register. A
// byte beat is accepted every cycle unless that register holds a result that
// is being stalled.
// ----------------------------------------------------------------------------
module ignition_packet_decoder_core
	import ipd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  logic               op,
	input  logic [7:0]         data_byte,
	input  logic               sim_active,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [2:0]         quantity,
	output logic signed [14:0] value,
	output logic [7:0]         raw_code
);

	logic [CNT_W-1:0] count_q;
	logic [7:0]       win [WIN_DEPTH];
	cell_ctrl_t       ctrl [WIN_DEPTH];
	logic             acc;
	logic             byte_ev;
	logic             full;
	logic             is_term;
	logic             append;
	logic             slide;
	logic             fire;
	logic             res_valid_q;
	qty_t             qty_q;
	logic signed [14:0] value_q;
	logic [7:0]       code_q;
	dec_res_t         dec;

	assign rx_stall = res_valid_q & res_stall;
	assign acc      = rx_valid & ~rx_stall;
	assign byte_ev  = acc & ~op & (data_byte != PAD_BYTE);
	assign full     = (count_q == CNT_W'(WIN_DEPTH));
	assign is_term  = (data_byte == TERM_SP) || (data_byte == TERM_CR);
	assign append   = byte_ev & ~full;
	assign slide    = byte_ev & full & ~is_term;
	assign fire     = byte_ev & full & is_term;

	for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
		assign ctrl[i].load  = append & (count_q == CNT_W'(i));
		assign ctrl[i].shift = slide;
		if (i == WIN_DEPTH - 1) begin : g_tail
			ipd_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl[i]),
				.new_byte  (data_byte),
				.next_byte (data_byte),
				.byte_q    (win[i])
			);
		end else begin : g_body
			ipd_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl[i]),
				.new_byte  (data_byte),
				.next_byte (win[i+1]),
				.byte_q    (win[i])
			);
		end
	end

	ipd_decode u_decode (
		.cmd        (win[0]),
		.msb        (win[1]),
		.lsb        (win[2]),
		.sim_active (sim_active),
		.res        (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc && op) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= '0;
		end else if (append) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || !res_stall) begin
			res_valid_q <= fire & dec.hit;
		end
	end

	// payload: hold while stalled
	always_ff @(posedge clk) begin
		if (fire && dec.hit) begin
			qty_q   <= dec.qty;
			value_q <= dec.value;
			code_q  <= dec.code;
		end
	end

	assign res_valid = res_valid_q;
	assign quantity  = qty_q;
	assign value     = value_q;
	assign raw_code  = code_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WIN_DEPTH))
		else $error("window count out of range");

	a_fire_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> count_q == '0)
		else $error("window not emptied after packet");

	a_slide_full: assert property (@(posedge clk) disable iff (!arst_n)
		slide |=> count_q == CNT_W'(WIN_DEPTH))
		else $error("window lost fill on slide");

	a_res_from_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(fire))
		else $error("result without terminated packet");

	a_res_qty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> quantity != 3'd7)
		else $error("bad quantity code");

endmodule
